// File: hdl/wds_pkg.sv
// Shared constants and types of the weighted destination sampler.
`default_nettype none

package wds_pkg;

  localparam int MAX_TERMINALS = 64;
  localparam int FRACTION_BITS = 16;

  localparam int IDX_W    = $clog2(MAX_TERMINALS);
  localparam int CNT_W    = $clog2(MAX_TERMINALS + 1);
  localparam int CUM_W    = FRACTION_BITS + 1;
  localparam int TOTAL_W  = FRACTION_BITS + 2;
  localparam int WEIGHT_W = FRACTION_BITS + 1;
  localparam int RANDOM_W = FRACTION_BITS;
  localparam int TC_W     = 7;
  localparam int DEST_W   = 6;
  localparam int STATUS_W = 2;

  localparam logic [TC_W-1:0]    TC_RESET  = TC_W'(MAX_TERMINALS);
  localparam logic [TOTAL_W-1:0] ONE_VALUE = TOTAL_W'(1) << FRACTION_BITS;
  localparam logic [CUM_W-1:0]   CUM_MAX   = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_DRAW = 1'b1
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ROW_BAD   = 2'd1,
    STATUS_LOAD_PAST = 2'd2
  } status_e;

endpackage : wds_pkg

`default_nettype wire

// File: hdl/wds_in_if.sv
// Input channel of the sampler: load and draw transactions.
`default_nettype none

interface wds_in_if
  import wds_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                kind;
  logic                restart;
  logic [WEIGHT_W-1:0] weight;
  logic [RANDOM_W-1:0] random_value;

  modport source (output valid, kind, restart, weight, random_value, input ready);
  modport sink   (input valid, kind, restart, weight, random_value, output ready);
endinterface : wds_in_if

`default_nettype wire

// File: hdl/wds_out_if.sv
// Output channel of the sampler: one result transaction per input transaction.
`default_nettype none

interface wds_out_if
  import wds_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [DEST_W-1:0]   destination;
  logic [STATUS_W-1:0] status;

  modport source (output valid, destination, status, input ready);
  modport sink   (input valid, destination, status, output ready);
endinterface : wds_out_if

`default_nettype wire

// File: hdl/wds_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module wds_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 17
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule : wds_ram

`default_nettype wire

// File: hdl/weighted_destination_sampler.sv
// Top level of the weighted destination sampler: row loading and inverse-CDF search.
`default_nettype none

//  Channel    Direction  Transaction                     Fields
//  item_i     in         load one weight / draw one      kind, restart, weight, random_value
//  result_o   out        one result per item             destination, status
//  cfg_*_i    in         write terminal_count            cfg_wdata_i (7 bits)
//
//  A load, a failed draw and a draw over a single terminal need no search. Any other
//  draw searches through the single read port of the cumulative table, one search
//  step a cycle; a count that is not a power of two can need fewer steps than the
//  next larger power of two would.
//  Reset clears the running total, the entry count and the terminal count (to 64);
//  the table itself is not cleared and needs no clearing pass.
//  A result waits in a pending register and then in the output register, so a
//  stalled output side blocks new items only once both are full.

module weighted_destination_sampler
  import wds_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [TC_W-1:0] cfg_wdata_i,
  wds_in_if.sink               item_i,
  wds_out_if.source            result_o
);

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

  state_e                state_q, state_d;
  logic [TC_W-1:0]       tc_q, tc_d;
  logic [TOTAL_W-1:0]    total_q, total_d;
  logic [CNT_W-1:0]      entries_q, entries_d;
  logic [IDX_W-1:0]      bot_q, bot_d;
  logic [CNT_W-1:0]      top_q, top_d;
  logic [IDX_W-1:0]      mid_q, mid_d;
  logic [RANDOM_W-1:0]   rnd_q, rnd_d;
  logic                  pend_valid_q, pend_valid_d;
  logic [DEST_W-1:0]     pend_dest_q, pend_dest_d;
  status_e               pend_status_q, pend_status_d;
  logic                  out_valid_q, out_valid_d;
  logic [DEST_W-1:0]     out_dest_q, out_dest_d;
  status_e               out_status_q, out_status_d;

  // Table port.
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [CUM_W-1:0]      ram_wdata;
  logic                  ram_re;
  logic [IDX_W-1:0]      ram_raddr;
  logic [CUM_W-1:0]      ram_rdata;

  logic                  accept;
  logic                  out_free;
  logic [CNT_W-1:0]      count_use;
  logic [TOTAL_W-1:0]    base_total;
  logic [CNT_W-1:0]      base_cnt;
  logic                  load_ok;
  logic [TOTAL_W:0]      load_sum;
  logic                  draw_ok;
  logic                  lt;
  logic [IDX_W-1:0]      bot_n;
  logic [CNT_W-1:0]      top_n;
  logic [CNT_W-1:0]      span;
  logic [IDX_W-1:0]      mid_n;

  wds_ram #(
    .DEPTH (MAX_TERMINALS),
    .WIDTH (CUM_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The output register frees up this cycle when it is empty or being taken.
  assign out_free     = !out_valid_q || result_o.ready;
  assign item_i.ready = (state_q == ST_IDLE) && (!pend_valid_q || out_free);
  assign accept       = item_i.valid && item_i.ready;

  assign result_o.valid       = out_valid_q;
  assign result_o.destination = out_dest_q;
  assign result_o.status      = out_status_q;

  // A count of zero acts as one, a count above the table depth as the depth.
  always_comb begin
    if (tc_q == '0) begin
      count_use = CNT_W'(1);
    end else if (tc_q > TC_W'(MAX_TERMINALS)) begin
      count_use = CNT_W'(MAX_TERMINALS);
    end else begin
      count_use = CNT_W'(tc_q);
    end
  end

  // Load datapath. A restart clears the running sum before the weight is stored.
  assign base_total = item_i.restart ? '0 : total_q;
  assign base_cnt   = item_i.restart ? '0 : entries_q;
  assign load_ok    = base_cnt < count_use;
  assign load_sum   = {1'b0, base_total} + (TOTAL_W + 1)'(item_i.weight);

  // A draw only searches a complete row whose weights add up to exactly one.
  assign draw_ok = (entries_q == count_use) && (total_q == ONE_VALUE);

  // One search step: the read data belongs to the entry at mid_q.
  assign lt    = ram_rdata < CUM_W'(rnd_q);
  assign bot_n = lt ? mid_q : bot_q;
  assign top_n = lt ? top_q : CNT_W'(mid_q);
  assign span  = top_n - CNT_W'(bot_n);
  assign mid_n = bot_n + IDX_W'(span >> 1);

  always_comb begin
    state_d       = state_q;
    tc_d          = cfg_we_i ? cfg_wdata_i : tc_q;
    total_d       = total_q;
    entries_d     = entries_q;
    bot_d         = bot_q;
    top_d         = top_q;
    mid_d         = mid_q;
    rnd_d         = rnd_q;
    pend_valid_d  = pend_valid_q;
    pend_dest_d   = pend_dest_q;
    pend_status_d = pend_status_q;
    out_valid_d   = out_valid_q;
    out_dest_d    = out_dest_q;
    out_status_d  = out_status_q;
    ram_we        = 1'b0;
    ram_waddr     = IDX_W'(base_cnt);
    ram_wdata     = (base_total > TOTAL_W'(CUM_MAX)) ? CUM_MAX : base_total[CUM_W-1:0];
    ram_re        = 1'b0;
    ram_raddr     = mid_n;

    // The pending result moves into the output register whenever it is free.
    if (out_free) begin
      out_valid_d  = pend_valid_q;
      out_dest_d   = pend_dest_q;
      out_status_d = pend_status_q;
      pend_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (item_i.kind == KIND_LOAD) begin
            pend_valid_d = 1'b1;
            if (load_ok) begin
              ram_we        = 1'b1;
              total_d       = load_sum[TOTAL_W] ? TOTAL_MAX : load_sum[TOTAL_W-1:0];
              entries_d     = base_cnt + CNT_W'(1);
              pend_dest_d   = DEST_W'(base_cnt);
              pend_status_d = STATUS_OK;
            end else begin
              pend_dest_d   = '0;
              pend_status_d = STATUS_LOAD_PAST;
            end
          end else if (!draw_ok) begin
            pend_valid_d  = 1'b1;
            pend_dest_d   = '0;
            pend_status_d = STATUS_ROW_BAD;
          end else if (count_use == CNT_W'(1)) begin
            // A single terminal needs no search.
            pend_valid_d  = 1'b1;
            pend_dest_d   = '0;
            pend_status_d = STATUS_OK;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = IDX_W'(count_use >> 1);
            bot_d     = '0;
            top_d     = count_use;
            mid_d     = IDX_W'(count_use >> 1);
            rnd_d     = item_i.random_value;
            state_d   = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        bot_d = bot_n;
        top_d = top_n;
        if (span > CNT_W'(1)) begin
          ram_re = 1'b1;
          mid_d  = mid_n;
        end else begin
          pend_valid_d  = 1'b1;
          pend_dest_d   = DEST_W'(bot_n);
          pend_status_d = STATUS_OK;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      tc_q          <= TC_RESET;
      total_q       <= '0;
      entries_q     <= '0;
      bot_q         <= '0;
      top_q         <= '0;
      mid_q         <= '0;
      rnd_q         <= '0;
      pend_valid_q  <= 1'b0;
      pend_dest_q   <= '0;
      pend_status_q <= STATUS_OK;
      out_valid_q   <= 1'b0;
      out_dest_q    <= '0;
      out_status_q  <= STATUS_OK;
    end else begin
      state_q       <= state_d;
      tc_q          <= tc_d;
      total_q       <= total_d;
      entries_q     <= entries_d;
      bot_q         <= bot_d;
      top_q         <= top_d;
      mid_q         <= mid_d;
      rnd_q         <= rnd_d;
      pend_valid_q  <= pend_valid_d;
      pend_dest_q   <= pend_dest_d;
      pend_status_q <= pend_status_d;
      out_valid_q   <= out_valid_d;
      out_dest_q    <= out_dest_d;
      out_status_q  <= out_status_d;
    end
  end

  // While searching, the pending slot has been drained and is free for the result.
  a_search_pend_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> !pend_valid_q)
    else $error("pending result present during search");

  // The search interval always holds more than one candidate while searching.
  a_search_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (top_q > CNT_W'(bot_q) + CNT_W'(1)))
    else $error("search interval collapsed");

  // The table is written only by loads taken in the idle state.
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (accept && (item_i.kind == KIND_LOAD)))
    else $error("table write outside a load");

  // A load past the terminal count leaves the row untouched.
  a_load_past_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (item_i.kind == KIND_LOAD) && !item_i.restart && !load_ok)
      |=> ($stable(entries_q) && $stable(total_q)))
    else $error("rejected load changed the row state");

  // The entry count never exceeds the table depth.
  a_entries_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entries_q <= CNT_W'(MAX_TERMINALS))
    else $error("entry count beyond table depth");

endmodule : weighted_destination_sampler

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench of the weighted destination sampler.
`default_nettype none

module tb;
  import wds_pkg::*;

  // One expected result: the terminal that a draw picks or the slot that a
  // load writes, and the status that goes with it.
  typedef struct {
    logic [DEST_W-1:0] destination;
    status_e           status;
  } pick_t;

  // Output stall patterns of the receiver.
  typedef enum int {
    RX_FREE,
    RX_COIN,
    RX_SPARSE,
    RX_LONG
  } rx_mode_e;

  // How a well-formed row spreads its unit of probability over the terminals.
  typedef enum int {
    SHAPE_FRONT,
    SHAPE_EVEN,
    SHAPE_SPIKE
  } weight_shape_e;

  localparam int RANDOM_ITEMS   = 1800;
  localparam int PHASE_ITEMS    = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int UNIT_WEIGHT    = 1 << FRACTION_BITS;
  localparam int WEIGHT_MAX     = (1 << WEIGHT_W) - 1;
  localparam int RANDOM_MAX     = (1 << RANDOM_W) - 1;

  // The scoreboard mirrors the sampler state. Every accepted transaction on
  // the input channel is turned into one expected pick, and every accepted
  // result is matched against the oldest pick still waiting.
  class sampler_scoreboard;
    logic [CUM_W-1:0]   cum_tab [MAX_TERMINALS];
    logic [TOTAL_W-1:0] row_total;
    logic [CNT_W-1:0]   loaded;
    logic [TC_W-1:0]    term_count;
    pick_t              expected_picks [$];
    int                 errors;

    function new();
      foreach (cum_tab[i]) cum_tab[i] = '0;
      row_total  = '0;
      loaded     = '0;
      term_count = TC_RESET;
      errors     = 0;
    endfunction

    function void set_count(logic [TC_W-1:0] value);
      term_count = value;
    endfunction

    // A count of zero behaves as one and a count above the table size is capped.
    function int count_in_use();
      if (term_count == '0) return 1;
      if (int'(term_count) > MAX_TERMINALS) return MAX_TERMINALS;
      return int'(term_count);
    endfunction

    function bit row_complete();
      return int'(loaded) == count_in_use() && row_total == ONE_VALUE;
    endfunction

    function int pending();
      return expected_picks.size();
    endfunction

    function void note_item(kind_e kind, logic restart, logic [WEIGHT_W-1:0] weight,
                            logic [RANDOM_W-1:0] rnd);
      pick_t pick;
      int    cnt;
      int    sum;
      int    lo;
      int    hi;
      int    mid;
      cnt              = count_in_use();
      pick.destination = '0;
      pick.status      = STATUS_OK;
      if (kind == KIND_LOAD) begin
        if (restart) begin
          row_total = '0;
          loaded    = '0;
        end
        if (int'(loaded) >= cnt) begin
          pick.status = STATUS_LOAD_PAST;
        end else begin
          // The table keeps the exclusive prefix sum; both stores saturate.
          sum = int'(row_total) + int'(weight);
          cum_tab[loaded] = (row_total > TOTAL_W'(CUM_MAX)) ? CUM_MAX : row_total[CUM_W-1:0];
          row_total = (sum > int'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(sum);
          pick.destination = DEST_W'(loaded);
          loaded = loaded + 1'b1;
        end
      end else if (!row_complete()) begin
        pick.status = STATUS_ROW_BAD;
      end else begin
        // Largest index whose cumulative value lies strictly below the draw, else index 0.
        lo = 0;
        hi = cnt;
        while (hi - lo > 1) begin
          mid = lo + (hi - lo) / 2;
          if (cum_tab[mid] < CUM_W'(rnd)) lo = mid;
          else hi = mid;
        end
        pick.destination = DEST_W'(lo);
      end
      expected_picks.push_back(pick);
    endfunction

    function void check_result(logic [DEST_W-1:0] destination, logic [STATUS_W-1:0] status);
      pick_t want;
      if (expected_picks.size() == 0) begin
        $display("%0t: result with nothing expected, destination %0d status %0d",
                 $time, destination, status);
        errors++;
        return;
      end
      want = expected_picks.pop_front();
      if (destination !== want.destination) begin
        $display("%0t: destination mismatch, expected %0d, actual %0d",
                 $time, want.destination, destination);
        errors++;
      end
      if (status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, want.status, status);
        errors++;
      end
    endfunction
  endclass

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            cfg_we    = 1'b0;
  logic [TC_W-1:0] cfg_wdata = '0;

  wds_in_if  item_if ();
  wds_out_if result_if ();

  sampler_scoreboard sb;

  int       items_sent  = 0;
  int       burst_left  = 0;
  int       idle_cycles = 0;
  rx_mode_e rx_mode     = RX_FREE;
  int       rx_left     = 0;
  int       rx_cycle    = 0;
  int       stall_left  = 0;

  weighted_destination_sampler u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (item_if),
    .result_o    (result_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The receiver picks a stall pattern for a random stretch of cycles: always
  // ready, a coin flip per cycle, ready for single cycles at a regular spacing, or long stalls
  // between ready stretches. Ready changes only at the falling edge.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(32, 256);
    end else begin
      rx_left--;
    end
    rx_cycle++;
    case (rx_mode)
      RX_FREE: begin
        result_if.ready = 1'b1;
      end
      RX_COIN: begin
        result_if.ready = 1'($urandom_range(0, 1));
      end
      RX_SPARSE: begin
        result_if.ready = (rx_cycle % 4 == 0);
      end
      default: begin
        if (stall_left > 0) begin
          result_if.ready = 1'b0;
          stall_left--;
        end else begin
          result_if.ready = 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(5, 30);
        end
      end
    endcase
  end

  // Results are taken at the rising edge, where the outputs still hold the
  // values of the cycle that ends.
  always @(posedge clk) begin
    if (rst_n && result_if.valid && result_if.ready) begin
      sb.check_result(result_if.destination, result_if.status);
    end
  end

  // The watchdog ends a run in which neither channel moves a transaction
  // for too long.
  always @(posedge clk) begin
    if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offers one transaction and returns at the edge that accepts it. The
  // sender works in bursts; between bursts valid may drop for a random gap.
  // Valid is only written at falling edges, once per edge, so an item that
  // follows directly keeps valid high without a glitch.
  task automatic send_item(kind_e kind, logic restart, int weight, int rnd);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        item_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    @(negedge clk);
    item_if.valid        = 1'b1;
    item_if.kind         = kind;
    item_if.restart      = restart;
    item_if.weight       = WEIGHT_W'(weight);
    item_if.random_value = RANDOM_W'(rnd);
    do @(posedge clk); while (!item_if.ready);
    sb.note_item(kind, restart, item_if.weight, item_if.random_value);
    items_sent++;
  endtask

  // The terminal count is only written once every result has come back, so
  // the sampler is idle and the scoreboard can switch at the same point.
  task automatic write_count(int value);
    @(negedge clk);
    item_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = TC_W'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_count(TC_W'(value));
    burst_left = 0;
  endtask

  // Loads n weights from terminal 0 on. They add up to one unit, and the
  // last weight is moved by skew to build rows whose total is off.
  task automatic load_row(int n, int skew);
    int            remaining;
    int            w;
    int            i;
    weight_shape_e shape;
    remaining = UNIT_WEIGHT;
    shape     = weight_shape_e'($urandom_range(0, 2));
    for (i = 0; i < n; i++) begin
      if (i == n - 1) begin
        w = remaining + skew;
        if (w < 0) w = 0;
        if (w > WEIGHT_MAX) w = WEIGHT_MAX;
      end else begin
        case (shape)
          SHAPE_FRONT: begin
            w = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, remaining));
          end
          SHAPE_EVEN: begin
            w = int'($urandom_range(0, 2 * remaining / (n - i)));
            if (w > remaining) w = remaining;
          end
          default: begin
            w = ($urandom_range(0, 7) == 0) ? remaining / 2 : 0;
          end
        endcase
        remaining -= w;
      end
      send_item(KIND_LOAD, i == 0, w, $urandom_range(0, RANDOM_MAX));
    end
  endtask

  // Draws k destinations. On a complete row half of the draws aim at a
  // cumulative boundary or one step to either side of it, where the strict
  // comparison of the search decides the pick.
  task automatic draw_burst(int k);
    int j;
    int v;
    repeat (k) begin
      if (sb.row_complete() && $urandom_range(0, 1) == 1) begin
        j = $urandom_range(0, sb.count_in_use() - 1);
        v = int'(sb.cum_tab[j]) + int'($urandom_range(0, 2)) - 1;
        if (v < 0) v = 0;
        if (v > RANDOM_MAX) v = RANDOM_MAX;
      end else begin
        v = $urandom_range(0, RANDOM_MAX);
      end
      send_item(KIND_DRAW, 1'($urandom_range(0, 1)), $urandom_range(0, WEIGHT_MAX), v);
    end
  endtask

  initial begin
    int count_menu [8];
    int cnt;
    int phase;
    int phase_end;
    int pick;
    int i;

    sb = new();
    count_menu = '{64, 1, 127, 2, 0, 65, 5, 64};
    item_if.valid        = 1'b0;
    item_if.kind         = KIND_LOAD;
    item_if.restart      = 1'b0;
    item_if.weight       = '0;
    item_if.random_value = '0;
    result_if.ready      = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. A draw right after reset finds an empty row.
    send_item(KIND_DRAW, 1'b0, 0, 0);

    // A single terminal: every draw picks it, a second load goes past the count.
    write_count(1);
    send_item(KIND_LOAD, 1'b1, UNIT_WEIGHT, 0);
    send_item(KIND_DRAW, 1'b0, 0, 0);
    send_item(KIND_DRAW, 1'b1, WEIGHT_MAX, RANDOM_MAX);
    send_item(KIND_LOAD, 1'b0, 5, 0);
    send_item(KIND_DRAW, 1'b0, 0, 12345);

    // A count of zero behaves as one terminal; a zero total fails the draw.
    write_count(0);
    send_item(KIND_DRAW, 1'b0, 0, RANDOM_MAX);
    send_item(KIND_LOAD, 1'b1, 0, 0);
    send_item(KIND_DRAW, 1'b0, 0, 100);

    // Three terminals with equal boundaries, then restarted loads of the largest weight,
    // a row with boundaries next to the draws, and a row cut short by a restart.
    write_count(3);
    send_item(KIND_LOAD, 1'b1, 0, 0);
    send_item(KIND_LOAD, 1'b0, UNIT_WEIGHT, 0);
    send_item(KIND_LOAD, 1'b0, 0, 0);
    send_item(KIND_DRAW, 1'b0, 0, 0);
    send_item(KIND_DRAW, 1'b0, 0, 1);
    send_item(KIND_DRAW, 1'b0, 0, RANDOM_MAX);
    send_item(KIND_LOAD, 1'b0, 7, 0);
    repeat (3) send_item(KIND_LOAD, 1'b1, WEIGHT_MAX, 0);
    send_item(KIND_DRAW, 1'b0, 0, 4242);
    send_item(KIND_LOAD, 1'b1, UNIT_WEIGHT - 1, 0);
    send_item(KIND_LOAD, 1'b0, 1, 0);
    send_item(KIND_LOAD, 1'b0, 0, 0);
    send_item(KIND_DRAW, 1'b0, 0, RANDOM_MAX);
    send_item(KIND_DRAW, 1'b0, 0, UNIT_WEIGHT - 2);
    send_item(KIND_LOAD, 1'b1, 1000, 0);
    send_item(KIND_DRAW, 1'b0, 0, 500);

    // Random part in phases, each under its own terminal count. The first
    // phases walk the extremes; later ones pick a count at random, most of
    // them small so that rows stay short.
    phase = 0;
    while (items_sent < RANDOM_ITEMS + 30) begin
      if (phase < 8) begin
        write_count(count_menu[phase]);
      end else if ($urandom_range(0, 3) == 0) begin
        write_count($urandom_range(0, (1 << TC_W) - 1));
      end else begin
        write_count($urandom_range(1, 12));
      end
      phase++;
      cnt = sb.count_in_use();
      phase_end = items_sent + PHASE_ITEMS;

      // The row loaded under the old count is checked against the new one.
      draw_burst(2);

      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 9);
        if (pick <= 5) begin
          // Well-formed row followed by draws.
          load_row(cnt, 0);
          draw_burst($urandom_range(1, 12));
        end else if (pick == 6) begin
          // Total a little above or below one unit.
          load_row(cnt, ($urandom_range(0, 1) == 1) ? int'($urandom_range(1, 2000))
                                                    : -int'($urandom_range(1, 2000)));
          draw_burst($urandom_range(1, 3));
        end else if (pick == 7) begin
          // Row cut short, or a single terminal whose total is off by one, then draws.
          if (cnt > 1) load_row($urandom_range(1, cnt - 1), 0);
          else load_row(1, 1);
          draw_burst(2);
        end else if (pick == 8) begin
          // Loads beyond the count leave the row untouched.
          load_row(cnt, 0);
          repeat ($urandom_range(1, 3)) begin
            send_item(KIND_LOAD, 1'b0, $urandom_range(0, WEIGHT_MAX), 0);
          end
          draw_burst(2);
        end else if ($urandom_range(0, 1) == 1) begin
          // Heavy weights can drive the running total and the table into saturation.
          for (i = 0; i < cnt; i++) begin
            send_item(KIND_LOAD, i == 0, $urandom_range(98304, WEIGHT_MAX), 0);
          end
          draw_burst(1);
        end else begin
          // Noise: every field at random.
          repeat ($urandom_range(1, 10)) begin
            send_item(kind_e'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      $urandom_range(0, WEIGHT_MAX), $urandom_range(0, RANDOM_MAX));
          end
        end
      end
    end

    // Drain: wait for the last results, then keep watching the output to catch
    // anything that should not come.
    @(negedge clk);
    item_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule : tb

`default_nettype wire

// File: weighted_destination_sampler.f
hdl/wds_pkg.sv
hdl/wds_in_if.sv
hdl/wds_out_if.sv
hdl/wds_ram.sv
hdl/weighted_destination_sampler.sv
dv/tb.sv
